FILE: rtl/core/bgi_pkg.sv
// bgi_pkg: shared constants, codes and state types of the bilinear grid interpolator.
// No dependencies; every other file of the block but bgi_ram imports it.
package bgi_pkg;

  localparam int DEF_MAX_COLUMNS = 16;
  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int FIELD_INDEX_BITS = 4;
  localparam int COUNT_BITS       = 5;
  localparam int CFG_INDEX_BITS   = 2;
  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;
  localparam int COUNT_MIN        = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_X    = 2'd0,
    CMD_LOAD_Y    = 2'd1,
    CMD_LOAD_GRID = 2'd2,
    CMD_QUERY     = 2'd3
  } bgi_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_ORDER = 2'd2
  } bgi_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_LERP0,
    ST_LERP1,
    ST_LERP2,
    ST_EMIT
  } bgi_state_e;

  typedef enum logic [1:0] {
    LP_IDLE,
    LP_MUL,
    LP_DIV,
    LP_SUM
  } bgi_lerp_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } bgi_lerp_ctrl_t;

endpackage

FILE: rtl/core/bgi_if.sv
// bgi_if: channel interfaces (input items, results, configuration writes).
// Depends on bgi_pkg.
interface bgi_in_if import bgi_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                                valid;
  logic                                ready;
  bgi_cmd_e                            cmd;
  logic        [FIELD_INDEX_BITS-1:0]  column_index;
  logic        [FIELD_INDEX_BITS-1:0]  row_index;
  logic signed [VALUE_BITS-1:0]        load_value;
  logic signed [VALUE_BITS-1:0]        query_x;
  logic signed [VALUE_BITS-1:0]        query_y;
  logic                                strict_check;

  modport source (output valid, cmd, column_index, row_index, load_value, query_x, query_y,
                  strict_check, input ready);
  modport sink   (input valid, cmd, column_index, row_index, load_value, query_x, query_y,
                  strict_check, output ready);
endinterface

interface bgi_out_if import bgi_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] result_value;
  bgi_status_e                  status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface bgi_cfg_if import bgi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [COUNT_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/bgi_ram.sv
// bgi_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/bgi_front.sv
// bgi_front: accepts input transactions, drops loads addressed outside the store
// and packs the rest into queue entries. Depends on bgi_pkg and bgi_if.
module bgi_front import bgi_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int EW = 2 + CW + RW + 3 * VALUE_BITS + 1
) (
  bgi_in_if.sink        in_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output logic [EW-1:0] entry_o
);

  logic col_ok, row_ok, keep;

  assign in_i.ready = !queue_full_i;

  always_comb begin
    col_ok = int'(in_i.column_index) < MAX_COLUMNS;
    row_ok = int'(in_i.row_index) < MAX_ROWS;
    unique case (in_i.cmd)
      CMD_LOAD_X:    keep = col_ok;
      CMD_LOAD_Y:    keep = row_ok;
      CMD_LOAD_GRID: keep = col_ok && row_ok;
      default:       keep = 1'b1;
    endcase
  end

  assign push_o  = in_i.valid && in_i.ready && keep;
  assign entry_o = {in_i.cmd, CW'(in_i.column_index), RW'(in_i.row_index), in_i.load_value,
                    in_i.query_x, in_i.query_y, in_i.strict_check};

endmodule

FILE: rtl/core/bgi_queue.sv
// bgi_queue: two-entry queue between front and back.
// Depends on bgi_pkg.
module bgi_queue import bgi_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/bgi_lerp.sv
// bgi_lerp: one interpolation step a + trunc((b-a)*(q-p0)/(p1-p0)), saturated,
// by a shift-add multiply then a restoring divide, one bit a cycle. Depends on bgi_pkg.
module bgi_lerp import bgi_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [VALUE_BITS-1:0] a_i,
  input  logic signed [VALUE_BITS-1:0] b_i,
  input  logic signed [VALUE_BITS-1:0] q_i,
  input  logic signed [VALUE_BITS-1:0] p0_i,
  input  logic signed [VALUE_BITS-1:0] p1_i,
  output logic                         done_o,
  output logic signed [VALUE_BITS-1:0] result_o
);

  localparam int W    = VALUE_BITS;
  localparam int D    = W + 1;
  localparam int P    = 2 * D;
  localparam int S    = P + 2;
  localparam int CNTW = $clog2(P);
  localparam logic signed [S-1:0] SAT_HI = {{(S-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [S-1:0] SAT_LO = {{(S-W+1){1'b1}}, {(W-1){1'b0}}};

  bgi_lerp_state_e state_q, state_d;
  logic signed [W-1:0] a_q, res_q;
  logic                neg_q, done_q;
  logic [D-1:0]        ma_q, mb_q, dd_q, rem_q, rem_d;
  logic [P-1:0]        acc_q, acc_d;
  logic [CNTW-1:0]     cnt_q;

  logic signed [D-1:0] dz, dq, dd;
  logic [D:0]          trial, diff;
  logic                ge;
  logic signed [S-1:0] av, sv, sum, sat;
  logic                load_en, mul_en, div_en, sum_en, last_mul, last_div;

  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    last_mul = cnt_q == CNTW'(D - 1);
    last_div = cnt_q == CNTW'(P - 1);
    unique case (state_q)
      LP_IDLE: state_d = start_i ? LP_MUL : LP_IDLE;
      LP_MUL:  state_d = last_mul ? LP_DIV : LP_MUL;
      LP_DIV:  state_d = last_div ? LP_SUM : LP_DIV;
      default: state_d = LP_IDLE;
    endcase
  end

  always_comb begin
    load_en = state_q == LP_IDLE && start_i;
    mul_en  = state_q == LP_MUL;
    div_en  = state_q == LP_DIV;
    sum_en  = state_q == LP_SUM;
  end

  always_comb begin
    dz    = {b_i[W-1], b_i} - {a_i[W-1], a_i};
    dq    = {q_i[W-1], q_i} - {p0_i[W-1], p0_i};
    dd    = {p1_i[W-1], p1_i} - {p0_i[W-1], p0_i};
    trial = {rem_q, acc_q[P-1]};
    diff  = trial - {1'b0, dd_q};
    ge    = trial >= {1'b0, dd_q};
    rem_d = ge ? diff[D-1:0] : trial[D-1:0];
    if (mul_en) begin
      acc_d = {acc_q[P-2:0], 1'b0} + (mb_q[D-1] ? {{D{1'b0}}, ma_q} : {P{1'b0}});
    end else begin
      acc_d = {acc_q[P-2:0], ge};
    end
    av  = {{(S-W){a_q[W-1]}}, a_q};
    sv  = {2'b00, acc_q};
    sum = neg_q ? av - sv : av + sv;
    if (sum > SAT_HI) begin
      sat = SAT_HI;
    end else if (sum < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LP_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= sum_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      a_q   <= a_i;
      neg_q <= dz[D-1] ^ dq[D-1];
      ma_q  <= dz[D-1] ? D'(-dz) : D'(dz);
      mb_q  <= dq[D-1] ? D'(-dq) : D'(dq);
      dd_q  <= D'(dd);
      acc_q <= '0;
      cnt_q <= '0;
    end
    if (mul_en) begin
      acc_q <= acc_d;
      mb_q  <= {mb_q[D-2:0], 1'b0};
      cnt_q <= last_mul ? '0 : cnt_q + 1'b1;
      rem_q <= '0;
    end
    if (div_en) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (sum_en) begin
      res_q <= W'(sat);
    end
  end

endmodule

FILE: rtl/core/bgi_back.sv
// bgi_back: executes queued loads and queries: axis checks, cell search, grid reads
// and three interpolation steps; holds configuration and the result register.
// Depends on bgi_pkg, bgi_if, bgi_ram and bgi_lerp.
module bgi_back import bgi_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int EW = 2 + CW + RW + 3 * VALUE_BITS + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          entry_valid_i,
  input  logic [EW-1:0] entry_i,
  output logic          entry_pop_o,
  bgi_cfg_if.sink       cfg_i,
  bgi_out_if.source     out_o
);

  localparam int W     = VALUE_BITS;
  localparam int CXN   = $clog2(MAX_COLUMNS + 1);
  localparam int CYN   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLUMNS);

  // queue entry fields
  bgi_cmd_e            e_kind;
  logic [CW-1:0]       e_col;
  logic [RW-1:0]       e_row;
  logic signed [W-1:0] e_val, e_qx, e_qy;
  logic                e_strict;

  assign e_kind   = bgi_cmd_e'(entry_i[EW-1 -: 2]);
  assign e_col    = entry_i[EW-3 -: CW];
  assign e_row    = entry_i[EW-3-CW -: RW];
  assign e_val    = entry_i[3*W : 2*W+1];
  assign e_qx     = entry_i[2*W : W+1];
  assign e_qy     = entry_i[W : 1];
  assign e_strict = entry_i[0];

  bgi_state_e state_q, state_d;
  logic [COUNT_BITS-1:0] cc_q, rc_q;
  logic signed [W-1:0]   x_pts_q [MAX_COLUMNS];
  logic signed [W-1:0]   y_pts_q [MAX_ROWS];
  logic signed [W-1:0]   qx_q, qy_q, x0_q, x1_q, y0_q, y1_q, r0_q, r1_q;
  logic signed [W-1:0]   g_q [4];
  logic                  strict_q, launched_q;
  logic [CW-1:0]         ix_q;
  logic [RW-1:0]         iy_q;
  logic [2:0]            rd_cnt_q;
  logic signed [W-1:0]   pend_res_q, res_q;
  bgi_status_e           pend_status_q, status_q;
  logic                  out_valid_q;

  logic [CXN-1:0] nx, ix_raw, ix_cl;
  logic [CYN-1:0] ny, iy_raw, iy_cl;
  logic           fault, oor;

  bgi_lerp_ctrl_t      lerp;
  logic signed [W-1:0] la, lb, lq, lp0, lp1, lres;
  logic                ram_we, ram_re, emit;
  logic [AW-1:0]       waddr, raddr;
  logic [W-1:0]        ram_rdata;
  logic [CW-1:0]       rd_col;
  logic [RW-1:0]       rd_row;
  logic                in_lerp;

  // cell search over the breakpoints in use
  always_comb begin
    if (int'(cc_q) < COUNT_MIN) begin
      nx = CXN'(COUNT_MIN);
    end else if (int'(cc_q) > MAX_COLUMNS) begin
      nx = CXN'(MAX_COLUMNS);
    end else begin
      nx = CXN'(cc_q);
    end
    if (int'(rc_q) < COUNT_MIN) begin
      ny = CYN'(COUNT_MIN);
    end else if (int'(rc_q) > MAX_ROWS) begin
      ny = CYN'(MAX_ROWS);
    end else begin
      ny = CYN'(rc_q);
    end
    fault = 1'b0;
    for (int i = 1; i < MAX_COLUMNS; i++) begin
      if (i < int'(nx) && x_pts_q[i] <= x_pts_q[i-1]) fault = 1'b1;
    end
    for (int i = 1; i < MAX_ROWS; i++) begin
      if (i < int'(ny) && y_pts_q[i] <= y_pts_q[i-1]) fault = 1'b1;
    end
    ix_raw = nx;
    for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
      if (i < int'(nx) && x_pts_q[i] >= qx_q) ix_raw = CXN'(i);
    end
    iy_raw = ny;
    for (int i = MAX_ROWS - 1; i >= 0; i--) begin
      if (i < int'(ny) && y_pts_q[i] >= qy_q) iy_raw = CYN'(i);
    end
    oor = strict_q && (ix_raw == nx || iy_raw == ny ||
                       (ix_raw == '0 && x_pts_q[0] != qx_q) ||
                       (iy_raw == '0 && y_pts_q[0] != qy_q));
    ix_cl = (ix_raw >= nx) ? nx - 1'b1 : ix_raw;
    if (ix_cl == '0) ix_cl = CXN'(1);
    iy_cl = (iy_raw >= ny) ? ny - 1'b1 : iy_raw;
    if (iy_cl == '0) iy_cl = CYN'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (entry_valid_i && e_kind == CMD_QUERY) state_d = ST_CHECK;
      ST_CHECK: state_d = (fault || oor) ? ST_EMIT : ST_READ;
      ST_READ:  if (rd_cnt_q == 3'd4) state_d = ST_LERP0;
      ST_LERP0: if (lerp.done) state_d = ST_LERP1;
      ST_LERP1: if (lerp.done) state_d = ST_LERP2;
      ST_LERP2: if (lerp.done) state_d = ST_EMIT;
      ST_EMIT:  if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_lerp     = state_q == ST_LERP0 || state_q == ST_LERP1 || state_q == ST_LERP2;
    entry_pop_o = state_q == ST_IDLE && entry_valid_i;
    ram_we      = entry_pop_o && e_kind == CMD_LOAD_GRID;
    ram_re      = state_q == ST_READ && rd_cnt_q != 3'd4;
    lerp.start  = in_lerp && !launched_q;
    emit        = state_q == ST_EMIT && (!out_valid_q || out_o.ready);
    rd_col      = rd_cnt_q[0] ? ix_q : ix_q - 1'b1;
    rd_row      = rd_cnt_q[1] ? iy_q : iy_q - 1'b1;
    waddr       = AW'(e_row) * ROW_STRIDE + AW'(e_col);
    raddr       = AW'(rd_row) * ROW_STRIDE + AW'(rd_col);
    if (state_q == ST_LERP2) begin
      la  = r0_q;
      lb  = r1_q;
      lq  = qy_q;
      lp0 = y0_q;
      lp1 = y1_q;
    end else begin
      la  = (state_q == ST_LERP1) ? g_q[2] : g_q[0];
      lb  = (state_q == ST_LERP1) ? g_q[3] : g_q[1];
      lq  = qx_q;
      lp0 = x0_q;
      lp1 = x1_q;
    end
  end

  bgi_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (e_val),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  bgi_lerp #(
    .VALUE_BITS (W)
  ) u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp.start),
    .a_i      (la),
    .b_i      (lb),
    .q_i      (lq),
    .p0_i     (lp0),
    .p1_i     (lp1),
    .done_o   (lerp.done),
    .result_o (lres)
  );

  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res_q;
  assign out_o.status       = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cc_q        <= COUNT_RESET;
      rc_q        <= COUNT_RESET;
      out_valid_q <= 1'b0;
      launched_q  <= 1'b0;
      rd_cnt_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == CFG_COLUMN_COUNT) cc_q <= cfg_i.data;
        if (cfg_i.index == CFG_ROW_COUNT)    rc_q <= cfg_i.data;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (lerp.start) begin
        launched_q <= 1'b1;
      end else if (lerp.done) begin
        launched_q <= 1'b0;
      end
      if (state_q == ST_CHECK) begin
        rd_cnt_q <= 3'd0;
      end else if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      qx_q     <= e_qx;
      qy_q     <= e_qy;
      strict_q <= e_strict;
      if (e_kind == CMD_LOAD_X) x_pts_q[e_col] <= e_val;
      if (e_kind == CMD_LOAD_Y) y_pts_q[e_row] <= e_val;
    end
    if (state_q == ST_CHECK) begin
      ix_q          <= CW'(ix_cl);
      iy_q          <= RW'(iy_cl);
      pend_res_q    <= '0;
      pend_status_q <= fault ? STATUS_ORDER : (oor ? STATUS_RANGE : STATUS_OK);
    end
    if (state_q == ST_READ) begin
      if (rd_cnt_q == 3'd0) begin
        x0_q <= x_pts_q[ix_q - 1'b1];
        y0_q <= y_pts_q[iy_q - 1'b1];
      end
      if (rd_cnt_q == 3'd1) begin
        x1_q <= x_pts_q[ix_q];
        y1_q <= y_pts_q[iy_q];
      end
      if (rd_cnt_q != 3'd0) g_q[2'(rd_cnt_q - 3'd1)] <= ram_rdata;
    end
    if (lerp.done) begin
      if (state_q == ST_LERP0) r0_q <= lres;
      if (state_q == ST_LERP1) r1_q <= lres;
      if (state_q == ST_LERP2) begin
        pend_res_q    <= lres;
        pend_status_q <= STATUS_OK;
      end
    end
    if (emit) begin
      res_q    <= pend_res_q;
      status_q <= pend_status_q;
    end
  end

endmodule

FILE: rtl/core/bilinear_grid_interpolator.sv
// bilinear_grid_interpolator: top level; front, two-entry queue and back.
// A query runs the bit-serial multiply and divide of the shared interpolation unit
// three times; the back executes one item at a time. Status-only answers (out of
// range, unordered axis) go from the check straight to the result.
// Reset (rst_ni, asynchronous): control clears, counts return to 16; stores are not cleared.
module bilinear_grid_interpolator import bgi_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bgi_in_if.sink    in_i,
  bgi_cfg_if.sink   cfg_i,
  bgi_out_if.source out_o
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = 2 + CW + RW + 3 * VALUE_BITS + 1;

  logic          push, full, pop, q_valid;
  logic [EW-1:0] push_data, q_data;

  bgi_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .in_i         (in_i),
    .queue_full_i (full),
    .push_o       (push),
    .entry_o      (push_data)
  );

  bgi_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  bgi_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_data),
    .entry_pop_o   (pop),
    .cfg_i         (cfg_i),
    .out_o         (out_o)
  );

endmodule

FILE: dv/bgi_checker.sv
// bgi_checker: watches the item, configuration and result channels of the grid
// interpolator, predicts every answer and compares it. Depends on bgi_pkg, bgi_if.
`timescale 1ns / 100ps
module bgi_checker import bgi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bgi_in_if    in_mon,
  bgi_cfg_if   cfg_mon,
  bgi_out_if   out_mon,
  output int   fail_count_o,
  output int   answers_due_o
);

  typedef struct {
    logic signed [31:0] value;
    bgi_status_e        status;
  } answer_t;

  longint      x_pts [16];
  longint      y_pts [16];
  longint      grid  [256];
  logic [4:0]  col_reg;
  logic [4:0]  row_reg;
  answer_t     answers_due [$];
  int          fail_count;

  assign fail_count_o  = fail_count;
  assign answers_due_o = answers_due.size();

  function automatic longint clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 64'sd2147483647;
    if (v < -128'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint q,
                                   input longint p0, input longint p1);
    logic signed [127:0] dz, dq, dd, mz, mq, s;
    dz = b - a;
    dq = q - p0;
    dd = p1 - p0;
    if (dd <= 0) return clip32(a);
    mz = dz < 0 ? -dz : dz;
    mq = dq < 0 ? -dq : dq;
    s  = (mz * mq) / dd;
    if (s > (128'sd1 <<< 62)) s = 128'sd1 <<< 62;
    if ((dz < 0) != (dq < 0)) return clip32(a - s);
    return clip32(a + s);
  endfunction

  function automatic int in_use(input logic [4:0] r);
    if (r < COUNT_MIN) return COUNT_MIN;
    return r > 16 ? 16 : int'(r);
  endfunction

  function automatic answer_t interpolate(input longint qx, input longint qy,
                                          input logic strict);
    answer_t ans;
    int      nx, ny, ix, iy;
    bit      ordered;
    longint  r0, r1;
    nx = in_use(col_reg);
    ny = in_use(row_reg);
    ans.value  = '0;
    ordered = 1'b1;
    for (int i = 1; i < nx; i++) if (x_pts[i] <= x_pts[i-1]) ordered = 1'b0;
    for (int i = 1; i < ny; i++) if (y_pts[i] <= y_pts[i-1]) ordered = 1'b0;
    if (!ordered) begin
      ans.status = STATUS_ORDER;
      return ans;
    end
    ix = nx;
    for (int i = nx - 1; i >= 0; i--) if (x_pts[i] >= qx) ix = i;
    iy = ny;
    for (int i = ny - 1; i >= 0; i--) if (y_pts[i] >= qy) iy = i;
    if (strict && (ix == nx || iy == ny || (ix == 0 && x_pts[0] != qx) ||
                   (iy == 0 && y_pts[0] != qy))) begin
      ans.status = STATUS_RANGE;
      return ans;
    end
    if (ix >= nx) ix = nx - 1;
    if (iy >= ny) iy = ny - 1;
    if (ix == 0) ix = 1;
    if (iy == 0) iy = 1;
    r0 = blend(grid[(iy-1)*16 + ix-1], grid[(iy-1)*16 + ix], qx, x_pts[ix-1], x_pts[ix]);
    r1 = blend(grid[iy*16 + ix-1], grid[iy*16 + ix], qx, x_pts[ix-1], x_pts[ix]);
    ans.value  = 32'(blend(r0, r1, qy, y_pts[iy-1], y_pts[iy]));
    ans.status = STATUS_OK;
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t due;
    if (!rst_ni) begin
      col_reg    <= COUNT_RESET;
      row_reg    <= COUNT_RESET;
      fail_count <= 0;
      answers_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_COLUMN_COUNT) col_reg <= cfg_mon.data;
        else if (cfg_mon.index == CFG_ROW_COUNT) row_reg <= cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_LOAD_X: begin
            x_pts[in_mon.column_index] = longint'(in_mon.load_value);
          end
          CMD_LOAD_Y: begin
            y_pts[in_mon.row_index] = longint'(in_mon.load_value);
          end
          CMD_LOAD_GRID: begin
            grid[in_mon.row_index*16 + in_mon.column_index] = longint'(in_mon.load_value);
          end
          default: begin
            answers_due.push_back(interpolate(longint'(in_mon.query_x),
                                              longint'(in_mon.query_y), in_mon.strict_check));
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d", $time,
                   out_mon.result_value, out_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          due = answers_due.pop_front();
          if (due.value !== out_mon.result_value || due.status !== out_mon.status) begin
            $display("%0t: mismatch expected value=%0d status=%0d, actual value=%0d status=%0d",
                     $time, due.value, due.status, out_mon.result_value, out_mon.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// tb_top: stimulus and verdict for bilinear_grid_interpolator; table loads,
// directed and random queries, register settings and flow-control phases. Uses bgi_checker.
`timescale 1ns / 100ps
module tb_top import bgi_pkg::*; ();

  localparam int CYCLE_LIMIT = 4000000;

  logic   clk_i;
  logic   rst_ni;
  int     fail_count;
  int     answers_due;
  int     src_idle_pct;
  int     snk_stall_pct;
  int     hold_cycles;
  longint cycle_count;
  longint x_axis [16];
  longint y_axis [16];

  bgi_in_if  in_if ();
  bgi_cfg_if cfg_if ();
  bgi_out_if out_if ();

  bilinear_grid_interpolator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  bgi_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .cfg_mon       (cfg_if),
    .out_mon       (out_if),
    .fail_count_o  (fail_count),
    .answers_due_o (answers_due)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result sink: random stalls plus an optional long hold
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic longint rand64();
    return longint'({$urandom, $urandom});
  endfunction

  function automatic longint pick(input longint lo, input longint hi);
    longint span;
    span = hi - lo + 1;
    return lo + longint'(unsigned'(rand64()) % unsigned'(span));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic send(input bgi_cmd_e cmd, input int col, input int row, input longint val,
                      input longint qx, input longint qy, input bit strict);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= cmd;
    in_if.column_index <= col[3:0];
    in_if.row_index    <= row[3:0];
    in_if.load_value   <= val[31:0];
    in_if.query_x      <= qx[31:0];
    in_if.query_y      <= qy[31:0];
    in_if.strict_check <= strict;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic load_x(input int i, input longint v);
    x_axis[i] = v;
    send(CMD_LOAD_X, i, $urandom_range(15), v, rand64(), rand64(), $urandom_range(1));
  endtask

  task automatic load_y(input int i, input longint v);
    y_axis[i] = v;
    send(CMD_LOAD_Y, $urandom_range(15), i, v, rand64(), rand64(), $urandom_range(1));
  endtask

  task automatic load_grid(input int c, input int r, input longint v);
    send(CMD_LOAD_GRID, c, r, v, rand64(), rand64(), $urandom_range(1));
  endtask

  task automatic query(input longint qx, input longint qy, input bit strict);
    send(CMD_QUERY, $urandom_range(15), $urandom_range(15), rand64(), qx, qy, strict);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (answers_due != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[4:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // strictly increasing axis; narrow mode gives tiny denominators
  task automatic reload_axes(input bit narrow);
    longint step_max, base;
    step_max = narrow ? 64'sd4 : longint'($urandom_range(1, 1 << 27));
    base     = pick(-64'sd2147483648, 64'sd2147483647 - 16 * step_max);
    for (int i = 0; i < 16; i++) begin
      base = base + (i == 0 ? 0 : pick(1, step_max));
      load_x(i, base);
    end
    base = pick(-64'sd2147483648, 64'sd2147483647 - 16 * step_max);
    for (int i = 0; i < 16; i++) begin
      base = base + (i == 0 ? 0 : pick(1, step_max));
      load_y(i, base);
    end
  endtask

  function automatic longint grid_value();
    case ($urandom_range(5))
      0: return 64'sd2147483647;
      1: return -64'sd2147483648;
      2: return pick(-1000, 1000);
      default: return longint'(signed'($urandom));
    endcase
  endfunction

  function automatic longint coord(input longint lo, input longint hi);
    longint span;
    span = hi - lo;
    case ($urandom_range(9))
      0, 1: return longint'(signed'($urandom));
      2: return lo;
      3: return hi;
      default: return clamp32(pick(lo - span / 4 - 1, hi + span / 4 + 1));
    endcase
  endfunction

  task automatic random_query();
    int ix, iy;
    ix = $urandom_range(15);
    iy = $urandom_range(15);
    if ($urandom_range(4) == 0) query(x_axis[ix], y_axis[iy], $urandom_range(1));
    else query(coord(x_axis[0], x_axis[15]), coord(y_axis[0], y_axis[15]),
               $urandom_range(1));
  endtask

  initial begin
    int col_set [8] = '{16, 2, 0, 31, 5, 1, 17, 9};
    int row_set [8] = '{16, 2, 1, 20, 9, 0, 31, 16};
    int slot;
    longint keep;
    rst_ni        = 1'b0;
    cycle_count   = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_cycles   = 0;
    in_if.valid   = 1'b0;
    in_if.cmd     = CMD_LOAD_X;
    in_if.column_index = '0;
    in_if.row_index    = '0;
    in_if.load_value   = '0;
    in_if.query_x      = '0;
    in_if.query_y      = '0;
    in_if.strict_check = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CFG_COLUMN_COUNT;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // whole table written before any query
    for (int i = 0; i < 16; i++) load_x(i, longint'(i) <<< 16);
    for (int i = 0; i < 16; i++) load_y(i, (longint'(i) * 2 - 10) <<< 16);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) load_grid(c, r, grid_value());

    // directed: edges, range, extrapolation, saturation, unordered axes
    query(x_axis[0], y_axis[0], 1'b1);
    query(x_axis[0], y_axis[3] + 5, 1'b1);
    query(x_axis[4] + 7, y_axis[0], 1'b1);
    query(x_axis[15], y_axis[15], 1'b1);
    query(x_axis[15] + 1, y_axis[2], 1'b1);
    query(x_axis[2], y_axis[0] - 1, 1'b1);
    query(x_axis[0] - 1, y_axis[15] + 1, 1'b1);
    query(-64'sd2147483648, -64'sd2147483648, 1'b0);
    query(64'sd2147483647, 64'sd2147483647, 1'b0);
    query(-64'sd2147483648, 64'sd2147483647, 1'b0);
    query(x_axis[7] + 32768, y_axis[8] + 12345, 1'b0);
    load_grid(15, 15, 64'sd2147483647);
    load_grid(14, 15, -64'sd2147483648);
    query(64'sd2147483647, y_axis[15], 1'b0);
    query(-64'sd2147483648, y_axis[15], 1'b1);
    keep = x_axis[3];
    load_x(3, x_axis[2]);
    query(x_axis[5], y_axis[5], 1'b1);
    query(x_axis[5], y_axis[5], 1'b0);
    load_x(3, keep);
    keep = y_axis[9];
    load_y(9, y_axis[10]);
    query(x_axis[1], y_axis[1], 1'b0);
    load_y(9, keep);
    query(x_axis[1], y_axis[1], 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_COLUMN_COUNT, col_set[ph]);
      write_reg(CFG_ROW_COUNT, row_set[ph]);
      src_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 22 : 65) : 0;
      snk_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 22 : 65) : 0;
      reload_axes(ph % 3 == 2);
      for (int k = 0; k < 80; k++) begin
        slot = $urandom_range(19);
        if (ph == 2 && k == 30) hold_cycles = 2000;
        if (ph == 5 && k == 60) begin
          in_if.valid <= 1'b0;
          while (answers_due != 0) @(negedge clk_i);
        end
        if (slot < 12) random_query();
        else if (slot < 16) load_grid($urandom_range(15), $urandom_range(15), grid_value());
        else if (slot == 16) begin
          // break an axis, query, then repair
          slot = $urandom_range(1, 15);
          keep = x_axis[slot];
          load_x(slot, longint'(signed'($urandom)));
          random_query();
          load_x(slot, keep);
        end else if (slot == 17) begin
          slot = $urandom_range(1, 15);
          keep = y_axis[slot];
          load_y(slot, y_axis[slot - 1]);
          random_query();
          load_y(slot, keep);
        end else if (slot == 18) begin
          slot = $urandom_range(1, 14);
          keep = x_axis[slot];
          load_x(slot, pick(x_axis[slot - 1] + 1 > x_axis[slot + 1] - 1 ? keep
                            : x_axis[slot - 1] + 1,
                            x_axis[slot - 1] + 1 > x_axis[slot + 1] - 1 ? keep
                            : x_axis[slot + 1] - 1));
        end else random_query();
      end
      drain();
    end

    while (hold_cycles != 0) @(negedge clk_i);
    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
